/* rtl/core/dtg_pkg.sv */
package dtg_pkg;

	localparam int PHASE_BITS_DEF  = 48;
	localparam int TABLE_DEPTH_DEF = 65536;

	localparam int SAMPLE_BITS = 14;
	localparam int DATA_BITS   = 32;
	localparam int LOOKUP_BITS = 16;
	localparam int CTRL_BITS   = 9;
	localparam int OPC_BITS    = 2;
	localparam int IDX_BITS    = 3;

	localparam logic [OPC_BITS-1:0] OP_TICK  = 2'd0;
	localparam logic [OPC_BITS-1:0] OP_WRITE = 2'd1;
	localparam logic [OPC_BITS-1:0] OP_READ  = 2'd2;

	localparam logic [IDX_BITS-1:0] IDX_CTRL    = 3'd0;
	localparam logic [IDX_BITS-1:0] IDX_TUNE_LO = 3'd1;
	localparam logic [IDX_BITS-1:0] IDX_TUNE_HI = 3'd2;
	localparam logic [IDX_BITS-1:0] IDX_OFFSET  = 3'd3;
	localparam logic [IDX_BITS-1:0] IDX_TADDR   = 3'd4;
	localparam logic [IDX_BITS-1:0] IDX_TDATA   = 3'd5;
	localparam logic [IDX_BITS-1:0] IDX_STATUS  = 3'd6;

	localparam int CTRL_EN_BIT    = 0;
	localparam int CTRL_WMODE_BIT = 8;

	localparam int OUT_DEPTH    = 4;
	localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);
	localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

	typedef struct packed {
		logic                   tick_en;
		logic                   sample_valid;
		logic                   read_valid;
		logic [DATA_BITS-1:0]   read_data;
		logic [LOOKUP_BITS-1:0] phase_top;
		logic [LOOKUP_BITS-1:0] shift;
	} item_t;

	typedef struct packed {
		logic                   we;
		logic [LOOKUP_BITS-1:0] addr;
		logic [SAMPLE_BITS-1:0] data;
	} table_wr_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   sample_valid;
		logic [DATA_BITS-1:0]   read_data;
		logic                   read_valid;
	} result_t;

endpackage

/* rtl/core/dds_tone_generator_registers_core.sv */
// Channel   Direction  tdata                                  tuser
// s_axis    in         [2:0] reg_index, [34:3] write_data     [1:0] opcode
// m_axis    out        [13:0] sample, [45:14] read_data       [0] sample_valid, [1] read_valid
//
// One item is accepted per clock while s_axis_tready is high; results pass s1, s2, the buffer.
// The wave table is a single-port-write, single-port-read memory with a registered read.
// Up to four items may be in flight; s_axis_tready falls only when four are outstanding.
// Reset clears the registers, the phase and the pipeline; table contents stay undefined.
// A stalled output holds its item while the pipeline keeps running into the output buffer.
module dds_tone_generator_registers_core #(
	parameter int PHASE_BITS  = dtg_pkg::PHASE_BITS_DEF,
	parameter int TABLE_DEPTH = dtg_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // reg_index, write_data
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // sample, read_data
	output logic [1:0]  m_axis_tuser   // sample_valid, read_valid
);

	logic               accept;
	logic               valid_s1;
	logic               valid_s2;
	dtg_pkg::item_t     item_s1;
	dtg_pkg::table_wr_t table_wr;
	dtg_pkg::result_t   result_s2;
	dtg_pkg::result_t   out_res;

	assign accept = s_axis_tvalid & s_axis_tready;

	dtg_regs #(
		.PHASE_BITS(PHASE_BITS)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (s_axis_tuser),
		.reg_index (s_axis_tdata[2:0]),
		.write_data(s_axis_tdata[34:3]),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.table_wr  (table_wr)
	);

	dtg_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.table_wr (table_wr),
		.valid_s2 (valid_s2),
		.result_s2(result_s2)
	);

	dtg_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (accept),
		.res_valid(valid_s2),
		.res      (result_s2),
		.out_ready(m_axis_tready),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.read_data, out_res.sample};
	assign m_axis_tuser = {out_res.read_valid, out_res.sample_valid};

endmodule

/* rtl/core/dtg_regs.sv */
module dtg_regs #(
	parameter int PHASE_BITS = dtg_pkg::PHASE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [dtg_pkg::OPC_BITS-1:0]   opcode,
	input  logic [dtg_pkg::IDX_BITS-1:0]   reg_index,
	input  logic [dtg_pkg::DATA_BITS-1:0]  write_data,
	output logic                           valid_s1,
	output dtg_pkg::item_t                 item_s1,
	output dtg_pkg::table_wr_t             table_wr
);

	logic [PHASE_BITS-1:0]               phase_q;
	logic [PHASE_BITS-1:0]               tune_q;
	logic [PHASE_BITS-1:0]               phase_sum;
	logic [dtg_pkg::LOOKUP_BITS-1:0]     shift_q;
	logic [dtg_pkg::LOOKUP_BITS-1:0]     taddr_q;
	logic [dtg_pkg::CTRL_BITS-1:0]       ctrl_q;
	logic [63:0]                         tune_ext;
	logic [63:0]                         tune_lo_wr;
	logic [63:0]                         tune_hi_wr;
	logic [dtg_pkg::DATA_BITS-1:0]       rd_mux;
	logic                                is_tick;
	logic                                is_write;
	logic                                is_read;

	assign is_tick  = (opcode == dtg_pkg::OP_TICK);
	assign is_write = (opcode == dtg_pkg::OP_WRITE);
	assign is_read  = (opcode == dtg_pkg::OP_READ);

	assign tune_ext   = 64'(tune_q);
	assign tune_lo_wr = {tune_ext[63:32], write_data};
	assign tune_hi_wr = {write_data, tune_ext[31:0]};
	assign phase_sum  = phase_q + tune_q;

	always_comb begin
		unique case (reg_index)
			dtg_pkg::IDX_CTRL:    rd_mux = 32'(ctrl_q);
			dtg_pkg::IDX_TUNE_LO: rd_mux = tune_ext[31:0];
			dtg_pkg::IDX_TUNE_HI: rd_mux = tune_ext[63:32];
			dtg_pkg::IDX_OFFSET:  rd_mux = 32'(shift_q);
			dtg_pkg::IDX_TADDR:   rd_mux = 32'(taddr_q);
			dtg_pkg::IDX_STATUS:  rd_mux = {30'd0, ctrl_q[dtg_pkg::CTRL_WMODE_BIT],
					ctrl_q[dtg_pkg::CTRL_EN_BIT]};
			default:              rd_mux = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			tune_q  <= '0;
			shift_q <= '0;
			taddr_q <= '0;
			ctrl_q  <= '0;
		end else if (accept) begin
			if (is_tick) begin
				if (ctrl_q[dtg_pkg::CTRL_EN_BIT]) begin
					phase_q <= phase_sum;
				end else begin
					phase_q <= '0;
				end
			end else if (is_write) begin
				unique case (reg_index)
					dtg_pkg::IDX_CTRL:    ctrl_q  <= write_data[dtg_pkg::CTRL_BITS-1:0];
					dtg_pkg::IDX_TUNE_LO: tune_q  <= tune_lo_wr[PHASE_BITS-1:0];
					dtg_pkg::IDX_TUNE_HI: tune_q  <= tune_hi_wr[PHASE_BITS-1:0];
					dtg_pkg::IDX_OFFSET:  shift_q <= write_data[dtg_pkg::LOOKUP_BITS-1:0];
					dtg_pkg::IDX_TADDR:   taddr_q <= write_data[dtg_pkg::LOOKUP_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.tick_en      <= is_tick & ctrl_q[dtg_pkg::CTRL_EN_BIT];
			item_s1.sample_valid <= is_tick;
			item_s1.read_valid   <= is_read;
			item_s1.read_data    <= is_read ? rd_mux : '0;
			item_s1.phase_top    <= phase_sum[PHASE_BITS-1 -: dtg_pkg::LOOKUP_BITS];
			item_s1.shift        <= shift_q;
		end
	end

	assign table_wr.we   = accept & is_write & (reg_index == dtg_pkg::IDX_TDATA) &
			ctrl_q[dtg_pkg::CTRL_WMODE_BIT];
	assign table_wr.addr = taddr_q;
	assign table_wr.data = write_data[dtg_pkg::SAMPLE_BITS-1:0];

endmodule

/* rtl/core/dtg_table.sv */
module dtg_table #(
	parameter int TABLE_DEPTH = dtg_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  dtg_pkg::item_t     item_s1,
	input  dtg_pkg::table_wr_t table_wr,
	output logic               valid_s2,
	output dtg_pkg::result_t   result_s2
);

	// The table depth is a power of two, so both addresses wrap by dropping high bits.
	localparam int AW = $clog2(TABLE_DEPTH);

	logic [dtg_pkg::SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
	logic [dtg_pkg::SAMPLE_BITS-1:0] rd_q;
	logic [dtg_pkg::LOOKUP_BITS-1:0] lookup_s1;
	logic                            tick_en_s2;
	logic                            sample_valid_s2;
	logic                            read_valid_s2;
	logic [dtg_pkg::DATA_BITS-1:0]   read_data_s2;

	assign lookup_s1 = item_s1.phase_top + item_s1.shift;

	// A write issued at acceptance lands before any later tick reads, and a read
	// colliding with a newer write returns the old entry, which preserves item order.
	always_ff @(posedge clk) begin
		if (table_wr.we) begin
			mem[table_wr.addr[AW-1:0]] <= table_wr.data;
		end
		if (valid_s1 && item_s1.tick_en) begin
			rd_q <= mem[lookup_s1[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tick_en_s2      <= item_s1.tick_en;
			sample_valid_s2 <= item_s1.sample_valid;
			read_valid_s2   <= item_s1.read_valid;
			read_data_s2    <= item_s1.read_data;
		end
	end

	assign result_s2.sample       = tick_en_s2 ? rd_q : '0;
	assign result_s2.sample_valid = sample_valid_s2;
	assign result_s2.read_data    = read_data_s2;
	assign result_s2.read_valid   = read_valid_s2;

endmodule

/* rtl/core/dtg_outbuf.sv */
module dtg_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             res_valid,
	input  dtg_pkg::result_t res,
	input  logic             out_ready,
	output logic             in_ready,
	output logic             out_valid,
	output dtg_pkg::result_t out_res
);

	dtg_pkg::result_t                   fifo_q [dtg_pkg::OUT_DEPTH];
	logic [dtg_pkg::OUT_PTR_BITS-1:0]   wr_ptr_q;
	logic [dtg_pkg::OUT_PTR_BITS-1:0]   rd_ptr_q;
	logic [dtg_pkg::OUT_CNT_BITS-1:0]   count_q;
	logic [dtg_pkg::OUT_CNT_BITS-1:0]   inflight_q;
	logic                               out_fire;

	// Items in the pipeline and in the buffer are counted together, so the buffer
	// can never overflow and the input ready never depends on the output ready.
	assign in_ready  = (inflight_q < dtg_pkg::OUT_CNT_BITS'(dtg_pkg::OUT_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_fire  = out_valid & out_ready;
	assign out_res   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			inflight_q <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q    <= count_q + dtg_pkg::OUT_CNT_BITS'(res_valid) -
					dtg_pkg::OUT_CNT_BITS'(out_fire);
			inflight_q <= inflight_q + dtg_pkg::OUT_CNT_BITS'(in_fire) -
					dtg_pkg::OUT_CNT_BITS'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	localparam int PHASE_W     = dtg_pkg::PHASE_BITS_DEF;
	localparam int TABLE_WORDS = dtg_pkg::TABLE_DEPTH_DEF;
	localparam int N_ITEMS     = 700;

	localparam logic [dtg_pkg::OPC_BITS-1:0] OP_NONE    = 2'd3;
	localparam logic [dtg_pkg::IDX_BITS-1:0] IDX_UNUSED = 3'd7;

	class tone_model;
		logic [PHASE_W-1:0]              phase;
		logic [PHASE_W-1:0]              tune;
		logic [dtg_pkg::LOOKUP_BITS-1:0] shift;
		logic [dtg_pkg::LOOKUP_BITS-1:0] taddr;
		logic [dtg_pkg::CTRL_BITS-1:0]   ctrl;
		logic [dtg_pkg::SAMPLE_BITS-1:0] wave [TABLE_WORDS];
		bit                              written [TABLE_WORDS];
		dtg_pkg::result_t                pending_outputs [$];
		int                              n_errors;
		int                              n_seen;

		function new();
			phase    = '0;
			tune     = '0;
			shift    = '0;
			taddr    = '0;
			ctrl     = '0;
			n_errors = 0;
			n_seen   = 0;
		endfunction

		function logic [dtg_pkg::LOOKUP_BITS-1:0] next_lookup();
			logic [PHASE_W-1:0] p;
			p = phase + tune;
			return p[PHASE_W-1 -: dtg_pkg::LOOKUP_BITS] + shift;
		endfunction

		function void note_item(logic [dtg_pkg::OPC_BITS-1:0] op,
				logic [dtg_pkg::IDX_BITS-1:0] idx, logic [dtg_pkg::DATA_BITS-1:0] data);
			dtg_pkg::result_t                r;
			logic [dtg_pkg::LOOKUP_BITS-1:0] a;
			r = '0;
			case (op)
				dtg_pkg::OP_TICK: begin
					r.sample_valid = 1'b1;
					if (ctrl[dtg_pkg::CTRL_EN_BIT]) begin
						a        = next_lookup();
						phase    = phase + tune;
						r.sample = wave[a];
					end else begin
						phase = '0;
					end
				end
				dtg_pkg::OP_WRITE: begin
					case (idx)
						dtg_pkg::IDX_CTRL:    ctrl = data[dtg_pkg::CTRL_BITS-1:0];
						dtg_pkg::IDX_TUNE_LO: tune[31:0] = data;
						dtg_pkg::IDX_TUNE_HI: tune[PHASE_W-1:32] = data[PHASE_W-33:0];
						dtg_pkg::IDX_OFFSET:  shift = data[dtg_pkg::LOOKUP_BITS-1:0];
						dtg_pkg::IDX_TADDR:   taddr = data[dtg_pkg::LOOKUP_BITS-1:0];
						dtg_pkg::IDX_TDATA: begin
							if (ctrl[dtg_pkg::CTRL_WMODE_BIT]) begin
								wave[taddr]    = data[dtg_pkg::SAMPLE_BITS-1:0];
								written[taddr] = 1'b1;
							end
						end
						default: ;
					endcase
				end
				dtg_pkg::OP_READ: begin
					r.read_valid = 1'b1;
					case (idx)
						dtg_pkg::IDX_CTRL:    r.read_data = dtg_pkg::DATA_BITS'(ctrl);
						dtg_pkg::IDX_TUNE_LO: r.read_data = tune[31:0];
						dtg_pkg::IDX_TUNE_HI:
							r.read_data = dtg_pkg::DATA_BITS'(tune[PHASE_W-1:32]);
						dtg_pkg::IDX_OFFSET:  r.read_data = dtg_pkg::DATA_BITS'(shift);
						dtg_pkg::IDX_TADDR:   r.read_data = dtg_pkg::DATA_BITS'(taddr);
						dtg_pkg::IDX_STATUS:
							r.read_data = {30'd0, ctrl[dtg_pkg::CTRL_WMODE_BIT],
								ctrl[dtg_pkg::CTRL_EN_BIT]};
						default:     r.read_data = '0;
					endcase
				end
				default: ;
			endcase
			pending_outputs.push_back(r);
		endfunction

		task report(string msg);
			n_errors++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_output(logic [47:0] td, logic [1:0] tu);
			dtg_pkg::result_t e;
			n_seen++;
			if (pending_outputs.size() == 0) begin
				report($sformatf("unexpected item tdata=%h tuser=%b", td, tu));
				return;
			end
			e = pending_outputs.pop_front();
			if (td[13:0] !== e.sample)
				report($sformatf("item %0d sample %h, want %h", n_seen, td[13:0], e.sample));
			if (tu[0] !== e.sample_valid)
				report($sformatf("item %0d sample_valid %b, want %b", n_seen, tu[0],
					e.sample_valid));
			if (td[45:14] !== e.read_data)
				report($sformatf("item %0d read_data %h, want %h", n_seen, td[45:14],
					e.read_data));
			if (tu[1] !== e.read_valid)
				report($sformatf("item %0d read_valid %b, want %b", n_seen, tu[1], e.read_valid));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // reg_index, write_data
	logic [1:0]  s_axis_tuser = '0;  // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // sample, read_data
	logic [1:0]  m_axis_tuser;       // sample_valid, read_valid

	tone_model model_h = new();
	bit        calm = 1'b0;
	int        n_sent = 0;

	dds_tone_generator_registers_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idle_cycles();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(logic [dtg_pkg::OPC_BITS-1:0] op,
			logic [dtg_pkg::IDX_BITS-1:0] idx, logic [dtg_pkg::DATA_BITS-1:0] data);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, data, idx};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		model_h.note_item(op, idx, data);
		n_sent++;
	endtask

	// An enabled tick must never look up an entry that was never written,
	// so the entry is filled first, with write mode raised only for that.
	task automatic tick();
		logic [dtg_pkg::LOOKUP_BITS-1:0] a;
		logic [dtg_pkg::CTRL_BITS-1:0]   saved;
		if (model_h.ctrl[dtg_pkg::CTRL_EN_BIT]) begin
			a = model_h.next_lookup();
			if (!model_h.written[a]) begin
				saved = model_h.ctrl;
				if (!saved[dtg_pkg::CTRL_WMODE_BIT])
					send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_CTRL,
						($urandom() << dtg_pkg::CTRL_BITS) | 32'(saved) |
						(32'd1 << dtg_pkg::CTRL_WMODE_BIT));
				send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TADDR,
					($urandom() << dtg_pkg::LOOKUP_BITS) | 32'(a));
				send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TDATA, $urandom());
				if (!saved[dtg_pkg::CTRL_WMODE_BIT])
					send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_CTRL,
						($urandom() << dtg_pkg::CTRL_BITS) | 32'(saved));
			end
		end
		send_item(dtg_pkg::OP_TICK, dtg_pkg::IDX_BITS'($urandom_range(0, 7)), $urandom());
	endtask

	initial begin
		logic [dtg_pkg::OPC_BITS-1:0]  op;
		logic [dtg_pkg::IDX_BITS-1:0]  idx;
		logic [dtg_pkg::DATA_BITS-1:0] data;
		int                            r;
		bit                            paused;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(dtg_pkg::OP_READ, dtg_pkg::IDX_TDATA, '1);
		send_item(dtg_pkg::OP_READ, dtg_pkg::IDX_STATUS, '1);
		send_item(dtg_pkg::OP_READ, IDX_UNUSED, '1);
		tick();
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_CTRL, '1);
		send_item(dtg_pkg::OP_READ, dtg_pkg::IDX_CTRL, '0);
		send_item(dtg_pkg::OP_READ, dtg_pkg::IDX_STATUS, '0);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TUNE_LO, '1);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TUNE_HI, '1);
		send_item(dtg_pkg::OP_READ, dtg_pkg::IDX_TUNE_HI, '0);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_OFFSET, '1);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TADDR, '1);
		send_item(dtg_pkg::OP_READ, dtg_pkg::IDX_OFFSET, '0);
		send_item(dtg_pkg::OP_READ, dtg_pkg::IDX_TADDR, '0);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TDATA, '1);
		tick();
		tick();
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_STATUS, '1);
		send_item(dtg_pkg::OP_WRITE, IDX_UNUSED, '1);
		send_item(OP_NONE, IDX_UNUSED, '1);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_CTRL, 32'd1 << dtg_pkg::CTRL_WMODE_BIT);
		tick();
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TUNE_LO, '0);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TUNE_HI, '0);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_OFFSET, 32'h0100);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TADDR, 32'h0100);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TDATA, 32'h1555);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_CTRL, 32'd1 << dtg_pkg::CTRL_EN_BIT);
		send_item(dtg_pkg::OP_WRITE, dtg_pkg::IDX_TDATA, 32'h2AAA);
		tick();

		while (n_sent < N_ITEMS) begin
			calm = (n_sent >= 300 && n_sent < 400);
			if (!paused && n_sent >= 450) begin
				paused = 1'b1;
				s_axis_tvalid <= 1'b0;
				while (model_h.pending_outputs.size() != 0) @(posedge clk);
			end
			r    = $urandom_range(0, 99);
			idx  = dtg_pkg::IDX_BITS'($urandom_range(0, 7));
			data = $urandom();
			if (r < 48) begin
				tick();
			end else begin
				if (r < 78)
					op = dtg_pkg::OP_WRITE;
				else if (r < 95)
					op = dtg_pkg::OP_READ;
				else
					op = OP_NONE;
				if (op == dtg_pkg::OP_WRITE && idx == dtg_pkg::IDX_CTRL)
					data[dtg_pkg::CTRL_EN_BIT] = ($urandom_range(0, 4) != 0);
				if (op == dtg_pkg::OP_WRITE && idx == dtg_pkg::IDX_TUNE_HI &&
						$urandom_range(0, 1) == 0)
					data = $urandom_range(0, 2);
				send_item(op, idx, data);
			end
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (model_h.pending_outputs.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (model_h.n_errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin : sink
		int stall_left;
		bit long_hold_done;
		stall_left     = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				model_h.check_output(m_axis_tdata, m_axis_tuser);
			if (!long_hold_done && model_h.n_seen >= 120) begin
				stall_left     = 64;
				long_hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_cycles();
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
